@@ rtl/core/dwc_pkg.sv @@
// ----------------------------------------------------------------------------
// dwc_pkg
// shared types, register indexes and widths of the depthwise 3x3 block
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int DEF_MAX_SIDE = 1024;
    localparam int PIX_W        = 16;
    localparam int IDX_W        = 10;
    localparam int SIDE_W       = 11;
    localparam int CFG_W        = 48;
    localparam int CFG_IDX_W    = 3;
    localparam int ACC_W        = 36;
    localparam int V_W          = 54;

    localparam logic [CFG_IDX_W-1:0] REG_SIDE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_W_TOP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_W_MID  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_W_BOT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FLAGS  = 3'd7;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic signed [15:0] pixel_value;
    } t_req;

    typedef struct packed {
        logic signed [15:0] out_value;
        logic [9:0]         out_row;
        logic [9:0]         out_col;
        logic               plane_last;
    } t_res;

    // one output to compute: the 3x3 window, row-major, and its position
    typedef struct packed {
        logic [8:0][PIX_W-1:0] pix;
        logic [IDX_W-1:0]      row;
        logic [IDX_W-1:0]      col;
        logic                  last;
    } t_job;

    typedef struct packed {
        logic               bias_en;
        logic               bn_en;
        logic               relu_en;
        logic signed [31:0] bias;
        logic signed [15:0] scale;
        logic signed [15:0] offset;
    } t_post;

endpackage

@@ rtl/core/depthwise_conv3x3_bn_relu.sv @@
// ----------------------------------------------------------------------------
// depthwise_conv3x3_bn_relu
// streaming 3x3 depthwise convolution with bias, batch-norm and relu
// ----------------------------------------------------------------------------
// requests enter through push/full, one pixel (or drain tick) each, in
// row-major order over an image_side x image_side plane. results leave through
// empty/pop in plane order. output (r-1,c-1) is produced by pixel (r,c) and the
// right-edge output of a row comes with the last pixel of the next row;
// image_side drain ticks after the last pixel flush the final row.
// the front takes a new request only when it is idle and the job queue has room
// for a row-end pair; it is busy while it reads and writes back the line stores.
// the back computes one output at a time: one job fetch, 9 multiply-accumulate
// steps on a single 16x16 multiplier, one batch-norm multiply, one output step
// that waits while the result queue is full. a 4-entry job queue lets the front
// run ahead of the back.
// reset empties both queues, clears the plane position and window and loads the
// register defaults; when pop stays low the result queue fills, the back
// stops, then the job queue runs short of room for a row-end pair and full rises.
// writing image_side starts a new plane.
// ----------------------------------------------------------------------------
module depthwise_conv3x3_bn_relu
    import dwc_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  t_req                 i_req,
    output logic                 empty,
    input  logic                 pop,
    output t_res                 o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    localparam int LW = $clog2(MAX_SIDE) + 1;
    localparam int JQ_DEPTH = 4;
    localparam int RQ_DEPTH = 2;
    localparam int JQ_CW = $clog2(JQ_DEPTH + 1);
    localparam int RQ_CW = $clog2(RQ_DEPTH + 1);

    logic [SIDE_W-1:0]  r_side;
    logic [CFG_W-1:0]   r_w_top, r_w_mid, r_w_bot;
    logic signed [31:0] r_bias;
    logic signed [15:0] r_scale, r_offset;
    logic [2:0]         r_flags;

    logic [LW-1:0]         side;
    logic [8:0][PIX_W-1:0] weights;
    t_post                 post;
    logic                  restart;

    logic        job_push, job_pop, jq_empty, jq_full, jq_room;
    logic [JQ_CW-1:0] jq_count;
    t_job        job_in, job_out;
    logic        res_push, rq_full;
    logic [RQ_CW-1:0] rq_count;
    t_res        res_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side   <= SIDE_W'(16);
            r_w_top  <= '0;
            r_w_mid  <= '0;
            r_w_bot  <= '0;
            r_bias   <= '0;
            r_scale  <= 16'sd4096;
            r_offset <= '0;
            r_flags  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIDE:   r_side   <= i_cfg_data[SIDE_W-1:0];
                REG_W_TOP:  r_w_top  <= i_cfg_data;
                REG_W_MID:  r_w_mid  <= i_cfg_data;
                REG_W_BOT:  r_w_bot  <= i_cfg_data;
                REG_BIAS:   r_bias   <= i_cfg_data[31:0];
                REG_SCALE:  r_scale  <= i_cfg_data[15:0];
                REG_OFFSET: r_offset <= i_cfg_data[15:0];
                REG_FLAGS:  r_flags  <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    assign restart = i_cfg_we && (i_cfg_idx == REG_SIDE);

    always_comb begin
        if (r_side < SIDE_W'(2)) begin
            side = LW'(2);
        end else if (32'(r_side) > MAX_SIDE) begin
            side = LW'(MAX_SIDE);
        end else begin
            side = LW'(r_side);
        end
        for (int j = 0; j < 3; j++) begin
            weights[j]   = r_w_top[j*16 +: 16];
            weights[3+j] = r_w_mid[j*16 +: 16];
            weights[6+j] = r_w_bot[j*16 +: 16];
        end
        post.bias_en = r_flags[0];
        post.bn_en   = r_flags[1];
        post.relu_en = r_flags[2];
        post.bias    = r_bias;
        post.scale   = r_scale;
        post.offset  = r_offset;
    end

    // room for a row-end pair of jobs
    assign jq_room = (jq_count <= JQ_CW'(JQ_DEPTH - 2));

    dwc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (restart),
        .i_side     (side),
        .i_push     (push),
        .i_req      (i_req),
        .o_full     (full),
        .i_jq_room  (jq_room),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    dwc_fifo #(
        .W     ($bits(t_job)),
        .DEPTH (JQ_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_din   (job_in),
        .i_pop   (job_pop),
        .o_dout  (job_out),
        .o_empty (jq_empty),
        .o_full  (jq_full),
        .o_count (jq_count)
    );

    dwc_mac u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_weights   (weights),
        .i_post      (post),
        .i_job_empty (jq_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .i_res_full  (rq_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    dwc_fifo #(
        .W     ($bits(t_res)),
        .DEPTH (RQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_din   (res_in),
        .i_pop   (pop),
        .o_dout  (o_res),
        .o_empty (empty),
        .o_full  (rq_full),
        .o_count (rq_count)
    );

    a_no_job_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !jq_full)
        else $error("job queue overflow");

    a_res_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rq_count <= RQ_CW'(RQ_DEPTH)))
        else $error("result queue count out of range");

    a_full_when_no_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !jq_room |-> full)
        else $error("request allowed without job queue room");
endmodule

@@ rtl/core/dwc_fifo.sv @@
// ----------------------------------------------------------------------------
// dwc_fifo
// small flop-based queue with occupancy count
// ----------------------------------------------------------------------------
module dwc_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [W-1:0]               i_din,
    input  logic                       i_pop,
    output logic [W-1:0]               o_dout,
    output logic                       o_empty,
    output logic                       o_full,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_count = r_cnt;
    assign o_dout  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            r_cnt <= r_cnt + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_din;
        end
    end
endmodule

@@ rtl/core/dwc_front.sv @@
// ----------------------------------------------------------------------------
// dwc_front
// plane walker: line stores, 3x3 window and output job generation
// ----------------------------------------------------------------------------
module dwc_front
    import dwc_pkg::*;
#(
    parameter int MAX_SIDE = DEF_MAX_SIDE
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  logic [$clog2(MAX_SIDE):0]     i_side,
    input  logic                          i_push,
    input  t_req                          i_req,
    output logic                          o_full,
    input  logic                          i_jq_room,
    output logic                          o_job_push,
    output t_job                          o_job
);
    localparam int CW = $clog2(MAX_SIDE);
    localparam int LW = CW + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PROC = 2'd1;
    localparam logic [1:0] S_EDGE = 2'd2;

    logic [PIX_W-1:0] r_upper [MAX_SIDE];
    logic [PIX_W-1:0] r_lower [MAX_SIDE];

    logic [1:0]            r_state, n_state;
    logic [CW-1:0]         r_row, r_col;
    logic [LW-1:0]         r_drain;
    logic [LW-1:0]         r_r;
    logic [CW-1:0]         r_c;
    logic [PIX_W-1:0]      r_p;
    logic                  r_is_drain;
    logic [PIX_W-1:0]      r_rd_up, r_rd_lo;
    logic [8:0][PIX_W-1:0] r_win;
    t_job                  r_edge_job;

    logic                  accept, match;
    logic [CW-1:0]         a_c;
    logic [LW-1:0]         a_r;
    logic [PIX_W-1:0]      top, mid;
    logic [8:0][PIX_W-1:0] base, w_new, w_zero;
    logic                  emit1, is_edge, c_last;
    t_job                  job1;

    assign o_full = !(r_state == S_IDLE && i_jq_room);
    assign accept = i_push && !o_full;
    assign match  = (i_req.req_type == REQ_DRAIN) == (r_drain != '0);
    assign a_c    = (r_drain != '0) ? CW'(r_drain - LW'(1)) : r_col;
    assign a_r    = (r_drain != '0) ? i_side : LW'(r_row);

    always_comb begin
        top    = (r_r >= LW'(2)) ? r_rd_up : '0;
        mid    = (r_r >= LW'(1)) ? r_rd_lo : '0;
        base   = (r_c == '0) ? '0 : r_win;
        for (int i = 0; i < 3; i++) begin
            w_new[i*3]    = base[i*3+1];
            w_new[i*3+1]  = base[i*3+2];
            w_zero[i*3]   = w_new[i*3+1];
            w_zero[i*3+1] = w_new[i*3+2];
            w_zero[i*3+2] = '0;
        end
        w_new[2] = top;
        w_new[5] = mid;
        w_new[8] = r_p;
        c_last   = (LW'(r_c) == i_side - LW'(1));
        emit1    = (r_r >= LW'(1)) && (r_c != '0);
        is_edge  = (r_r >= LW'(1)) && c_last;
        job1.pix  = w_new;
        job1.row  = IDX_W'(r_r - LW'(1));
        job1.col  = IDX_W'(r_c - CW'(1));
        job1.last = 1'b0;
    end

    always_comb begin
        o_job_push = 1'b0;
        o_job      = job1;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && match) begin
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                o_job_push = emit1;
                n_state    = is_edge ? S_EDGE : S_IDLE;
            end
            S_EDGE: begin
                o_job_push = 1'b1;
                o_job      = r_edge_job;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= '0;
            r_win   <= '0;
        end else if (i_restart) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_drain <= '0;
            r_win   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PROC) begin
                // every row, and so a new plane, starts at column zero, which clears the window
                r_win <= is_edge ? w_zero : w_new;
                if (r_is_drain) begin
                    if (c_last) begin
                        r_row   <= '0;
                        r_col   <= '0;
                        r_drain <= '0;
                    end else begin
                        r_drain <= r_drain + LW'(1);
                    end
                end else if (c_last) begin
                    r_col <= '0;
                    if (LW'(r_row) + LW'(1) == i_side) begin
                        r_row   <= '0;
                        r_drain <= LW'(1);
                    end else begin
                        r_row <= r_row + CW'(1);
                    end
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
        end
    end

    // item latch, line store read and write-back and edge job capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept && match) begin
            r_r        <= a_r;
            r_c        <= a_c;
            // drain ticks act as zero pixels
            r_p        <= (i_req.req_type == REQ_DRAIN) ? '0 : i_req.pixel_value;
            r_is_drain <= i_req.req_type;
            r_rd_up    <= r_upper[a_c];
            r_rd_lo    <= r_lower[a_c];
        end
        if (r_state == S_PROC) begin
            r_edge_job.pix  <= w_zero;
            r_edge_job.row  <= IDX_W'(r_r - LW'(1));
            r_edge_job.col  <= IDX_W'(i_side - LW'(1));
            r_edge_job.last <= (r_r == i_side);
            if (!r_is_drain) begin
                r_upper[r_c] <= r_rd_lo;
                r_lower[r_c] <= r_p;
            end
        end
    end

    a_edge_after_proc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> $past(r_state) == S_PROC)
        else $error("edge job without a processed item");

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_full)
        else $error("request taken while an item is in flight");

    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain <= i_side))
        else $error("drain count past the plane side");
endmodule

@@ rtl/core/dwc_mac.sv @@
// ----------------------------------------------------------------------------
// dwc_mac
// iterative 3x3 multiply-accumulate with bias, batch-norm, relu and saturation
// ----------------------------------------------------------------------------
module dwc_mac
    import dwc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [8:0][PIX_W-1:0] i_weights,
    input  t_post                 i_post,
    input  logic                  i_job_empty,
    input  t_job                  i_job,
    output logic                  o_job_pop,
    input  logic                  i_res_full,
    output logic                  o_res_push,
    output t_res                  o_res
);
    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_MAC  = 2'd1;
    localparam logic [1:0] B_MUL  = 2'd2;
    localparam logic [1:0] B_OUT  = 2'd3;

    logic [1:0]             r_state;
    logic [3:0]             r_k;
    t_job                   r_job;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [V_W-1:0]   r_v;

    logic signed [31:0]     prod;
    logic signed [V_W-1:0]  sum, shifted;
    logic signed [V_W-1:0]  val;

    always_comb begin
        prod    = $signed(r_job.pix[r_k]) * $signed(i_weights[r_k]);
        if (i_post.bn_en) begin
            sum     = r_v + (V_W'(i_post.offset) <<< 26) + (V_W'(1) <<< 25);
            shifted = sum >>> 26;
        end else begin
            sum     = r_v + (V_W'(1) <<< 13);
            shifted = sum >>> 14;
        end
        val = shifted;
        if (i_post.relu_en && val < 0) begin
            val = '0;
        end
        o_res.out_row    = r_job.row;
        o_res.out_col    = r_job.col;
        o_res.plane_last = r_job.last;
        if (val > V_W'(32767)) begin
            o_res.out_value = 16'sh7fff;
        end else if (val < -V_W'(32768)) begin
            o_res.out_value = 16'sh8000;
        end else begin
            o_res.out_value = val[15:0];
        end
    end

    assign o_job_pop  = (r_state == B_IDLE) && !i_job_empty;
    assign o_res_push = (r_state == B_OUT) && !i_res_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_k     <= '0;
        end else begin
            case (r_state)
                B_IDLE: begin
                    if (!i_job_empty) begin
                        r_state <= B_MAC;
                        r_k     <= '0;
                    end
                end
                B_MAC: begin
                    r_k <= r_k + 4'd1;
                    if (r_k == 4'd8) begin
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_state <= B_OUT;
                end
                B_OUT: begin
                    if (!i_res_full) begin
                        r_state <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == B_IDLE) begin
            r_job <= i_job;
            r_acc <= i_post.bias_en ? ACC_W'(i_post.bias) : '0;
        end
        if (r_state == B_MAC) begin
            r_acc <= r_acc + ACC_W'(prod);
        end
        if (r_state == B_MUL) begin
            r_v <= i_post.bn_en ? V_W'(r_acc * i_post.scale) : V_W'(r_acc);
        end
    end
endmodule

@@ verif/depthwise_conv3x3_bn_relu_test.sv @@
// ----------------------------------------------------------------------------
// depthwise_conv3x3_bn_relu_test
// self-checking bench for the streaming 3x3 depthwise convolution
// ----------------------------------------------------------------------------
// a short table of directed requests (reset state, identity kernel, ignored
// requests, clamped sides, extreme registers) is followed by random phases of
// register settings and square planes. every accepted request steps a
// behavioral copy of the convolution window and line stores; its outputs are
// queued and compared field by field with each popped result. the sender runs
// in random bursts, the receiver stalls on its own rotating pattern.
// ----------------------------------------------------------------------------
module depthwise_conv3x3_bn_relu_test;
    import dwc_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 20000;
    localparam int RAND_ITEMS    = 1030;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_DRAIN} row_kind_e;

    typedef struct packed {
        row_kind_e          kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]   data;
        logic [15:0]        pix;
        logic               chk;
        logic [15:0]        val;
    } dir_row_t;

    typedef struct packed {
        t_req        req;
        logic        chk;
        logic [15:0] val;
    } stim_t;

    localparam int DIR_ROWS = 31;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_DRAIN, REG_SIDE,   48'd0,            16'd0,      1'b0, 16'd0},
        '{ROW_CFG,   REG_SIDE,   48'd0,            16'd0,      1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'h7FFF,   1'b1, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'h8000,   1'b1, 16'd0},
        '{ROW_DRAIN, REG_SIDE,   48'd0,            16'd0,      1'b1, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'd1,      1'b1, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'hFFFF,   1'b1, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'd5,      1'b1, 16'd0},
        '{ROW_DRAIN, REG_SIDE,   48'd0,            16'd0,      1'b1, 16'd0},
        '{ROW_DRAIN, REG_SIDE,   48'd0,            16'd0,      1'b1, 16'd0},
        // centre weight of one: output equals input
        '{ROW_CFG,   REG_W_MID,  48'h0000_4000_0000, 16'd0,    1'b0, 16'd0},
        '{ROW_CFG,   REG_SIDE,   48'd2,            16'd0,      1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'd100,    1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'hFF38,   1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'h7FFF,   1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'h7FFF,   1'b0, 16'd0},
        '{ROW_DRAIN, REG_SIDE,   48'd0,            16'd0,      1'b0, 16'd0},
        '{ROW_DRAIN, REG_SIDE,   48'd0,            16'd0,      1'b1, 16'h7FFF},
        '{ROW_CFG,   REG_FLAGS,  48'd7,            16'd0,      1'b0, 16'd0},
        '{ROW_CFG,   REG_SCALE,  48'h8000,         16'd0,      1'b0, 16'd0},
        '{ROW_CFG,   REG_OFFSET, 48'h7FFF,         16'd0,      1'b0, 16'd0},
        '{ROW_CFG,   REG_BIAS,   48'h8000_0000,    16'd0,      1'b0, 16'd0},
        '{ROW_CFG,   REG_W_TOP,  48'hFFFF_FFFF_FFFF, 16'd0,    1'b0, 16'd0},
        '{ROW_CFG,   REG_W_BOT,  48'h7FFF_7FFF_7FFF, 16'd0,    1'b0, 16'd0},
        '{ROW_CFG,   REG_SIDE,   48'd2,            16'd0,      1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'h8000,   1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'h7FFF,   1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'h8000,   1'b0, 16'd0},
        '{ROW_PIX,   REG_SIDE,   48'd0,            16'h7FFF,   1'b0, 16'd0},
        '{ROW_DRAIN, REG_SIDE,   48'd0,            16'd0,      1'b0, 16'd0},
        // widest side clamps to the maximum; the plane is cut by the next write
        '{ROW_CFG,   REG_SIDE,   48'd2047,         16'd0,      1'b0, 16'd0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_req                 i_req = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_res                 o_res;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    depthwise_conv3x3_bn_relu DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_req      (i_req),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // convolution state as the block should hold it
    logic [10:0]        side_reg;
    logic [47:0]        wrow [3];
    logic signed [31:0] bias_reg;
    logic signed [15:0] scale_reg;
    logic signed [15:0] offset_reg;
    logic [2:0]         flags_reg;
    logic signed [15:0] row_upper [DEF_MAX_SIDE];
    logic signed [15:0] row_lower [DEF_MAX_SIDE];
    logic signed [15:0] win [3][3];
    int                 row_pos, col_pos, drain_pos;

    t_res expected_out [$];
    stim_t batch [$];
    int    errors = 0;
    int    items_used = 0;
    int    burst_left = 0;

    function automatic int plane_side();
        if (side_reg < 2) return 2;
        if (side_reg > DEF_MAX_SIDE) return DEF_MAX_SIDE;
        return int'(side_reg);
    endfunction

    task automatic clear_plane();
        row_pos = 0;
        col_pos = 0;
        drain_pos = 0;
        foreach (win[i, j]) win[i][j] = '0;
    endtask

    task automatic shift_window(logic signed [15:0] t, logic signed [15:0] m,
                                logic signed [15:0] b);
        logic signed [15:0] nv [3];
        nv[0] = t; nv[1] = m; nv[2] = b;
        for (int i = 0; i < 3; i++) begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
            win[i][2] = nv[i];
        end
    endtask

    task automatic queue_output(int r, int c, bit last, stim_t s);
        longint acc, v;
        t_res   e;
        acc = 0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                acc += longint'(win[i][j]) * longint'($signed(wrow[i][16*j +: 16]));
        if (flags_reg[0]) acc += longint'(bias_reg);
        if (flags_reg[1])
            v = (acc * longint'(scale_reg) + (longint'(offset_reg) <<< 26)
                 + (64'sd1 <<< 25)) >>> 26;
        else
            v = (acc + 64'sd8192) >>> 14;
        if (flags_reg[2] && v < 0) v = 0;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        e.out_value  = s.chk ? s.val : v[15:0];
        e.out_row    = r[9:0];
        e.out_col    = c[9:0];
        e.plane_last = last;
        expected_out.push_back(e);
    endtask

    task automatic convolve_step(stim_t s);
        int l, r, c;
        bit drain;
        logic signed [15:0] p, t, m;
        l = plane_side();
        drain = (s.req.req_type == REQ_DRAIN);
        // a drain between pixels or a pixel while draining is dropped
        if (drain != (drain_pos != 0)) return;
        items_used++;
        if (drain) begin
            r = l; c = drain_pos - 1; p = '0;
        end else begin
            r = row_pos; c = col_pos; p = s.req.pixel_value;
        end
        if (c >= l) c = l - 1;
        if (c == 0) foreach (win[i, j]) win[i][j] = '0;
        t = (r >= 2) ? row_upper[c] : '0;
        m = (r >= 1) ? row_lower[c] : '0;
        shift_window(t, m, p);
        if (!drain) begin
            row_upper[c] = row_lower[c];
            row_lower[c] = p;
        end
        if (r >= 1 && c >= 1) queue_output(r - 1, c - 1, 1'b0, s);
        if (r >= 1 && c == l - 1) begin
            shift_window('0, '0, '0);
            queue_output(r - 1, l - 1, r == l, s);
        end
        if (drain) begin
            if (c == l - 1) clear_plane();
            else drain_pos++;
        end else begin
            col_pos = c + 1;
            if (col_pos == l) begin
                col_pos = 0;
                row_pos = r + 1;
                if (row_pos == l) begin
                    row_pos = 0;
                    drain_pos = 1;
                end
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_SIDE: begin
                side_reg = data[10:0];
                clear_plane();
            end
            REG_W_TOP:  wrow[0] = data;
            REG_W_MID:  wrow[1] = data;
            REG_W_BOT:  wrow[2] = data;
            REG_BIAS:   bias_reg = data[31:0];
            REG_SCALE:  scale_reg = data[15:0];
            REG_OFFSET: offset_reg = data[15:0];
            REG_FLAGS:  flags_reg = data[2:0];
            default: ;
        endcase
    endtask

    task automatic send_batch();
        for (int i = 0; i < batch.size(); i++) begin
            push  <= 1'b1;
            i_req <= batch[i].req;
            do @(posedge i_clk); while (full);
            convolve_step(batch[i]);
            if (burst_left == 0 || i == batch.size() - 1) begin
                push <= 1'b0;
                if (burst_left == 0) begin
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    burst_left = $urandom_range(0, 3) == 0 ? 200 : $urandom_range(1, 30);
                end
            end else begin
                burst_left--;
            end
        end
        batch.delete();
    endtask

    task automatic wait_idle();
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_pixel();
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2, 3, 4, 5: return 16'($urandom);
            default: return 16'($urandom_range(0, 4096) - 2048);
        endcase
    endfunction

    function automatic logic [47:0] rand_weights();
        logic [47:0] w;
        for (int j = 0; j < 3; j++)
            w[16*j +: 16] = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 16384) - 8192);
        return w;
    endfunction

    task automatic random_settings();
        int sd;
        sd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 12) : $urandom_range(2, 8);
        write_reg(REG_SIDE, 48'(sd));
        write_reg(REG_W_TOP, rand_weights());
        write_reg(REG_W_MID, rand_weights());
        write_reg(REG_W_BOT, rand_weights());
        write_reg(REG_BIAS, ($urandom_range(0, 3) == 0) ? 48'($urandom)
                  : 48'(32'($urandom_range(0, 1 << 20) - (1 << 19))));
        write_reg(REG_SCALE, ($urandom_range(0, 3) == 0) ? 48'($urandom_range(0, 65535))
                  : 48'($urandom_range(2048, 8192)));
        write_reg(REG_OFFSET, ($urandom_range(0, 1) == 0) ? 48'($urandom_range(0, 65535))
                  : 48'(16'($urandom_range(0, 2048) - 1024)));
        write_reg(REG_FLAGS, 48'($urandom_range(0, 7)));
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_plane();
        int l, total, cut;
        stim_t s;
        l = plane_side();
        total = l * l + l;
        cut = ($urandom_range(0, 24) == 0) ? $urandom_range(1, total - 1) : total;
        for (int n = 0; n < cut; n++) begin
            s.chk = 1'b0;
            s.val = '0;
            if ($urandom_range(0, 19) == 0) begin
                // out-of-place request, dropped by the block
                s.req.req_type    = (n < l * l) ? REQ_DRAIN : REQ_PIXEL;
                s.req.pixel_value = 16'($urandom);
                batch.push_back(s);
            end
            s.req.req_type    = (n < l * l) ? REQ_PIXEL : REQ_DRAIN;
            s.req.pixel_value = (n < l * l) ? rand_pixel() : 16'($urandom);
            batch.push_back(s);
        end
    endtask

    task automatic check_result(t_res got);
        t_res e;
        if (expected_out.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            errors++;
            return;
        end
        e = expected_out.pop_front();
        if (got.out_value !== e.out_value) begin
            $display("%0t: out_value expected %0d actual %0d", $time,
                     $signed(e.out_value), $signed(got.out_value));
            errors++;
        end
        if (got.out_row !== e.out_row) begin
            $display("%0t: out_row expected %0d actual %0d", $time, e.out_row, got.out_row);
            errors++;
        end
        if (got.out_col !== e.out_col) begin
            $display("%0t: out_col expected %0d actual %0d", $time, e.out_col, got.out_col);
            errors++;
        end
        if (got.plane_last !== e.plane_last) begin
            $display("%0t: plane_last expected %0b actual %0b", $time,
                     e.plane_last, got.plane_last);
            errors++;
        end
    endtask

    // receiver: rotates between free flow, coin toss, rare pops and periodic stalls
    int unsigned pop_phase = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) check_result(o_res);
            pop_phase <= pop_phase + 1;
            case (pop_phase[8:7])
                2'd0: pop <= 1'b1;
                2'd1: pop <= 1'($urandom_range(0, 1));
                2'd2: pop <= ($urandom_range(0, 7) == 0);
                default: pop <= (pop_phase[4:0] < 5'd20);
            endcase
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        stim_t s;
        side_reg   = 11'd16;
        foreach (wrow[i]) wrow[i] = '0;
        bias_reg   = '0;
        scale_reg  = 16'sd4096;
        offset_reg = '0;
        flags_reg  = '0;
        clear_plane();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[k]) begin
            if (DIR_TAB[k].kind == ROW_CFG) begin
                send_batch();
                wait_idle();
                write_reg(DIR_TAB[k].idx, DIR_TAB[k].data);
                i_cfg_we <= 1'b0;
            end else begin
                s.req.req_type    = (DIR_TAB[k].kind == ROW_DRAIN) ? REQ_DRAIN : REQ_PIXEL;
                s.req.pixel_value = DIR_TAB[k].pix;
                s.chk             = DIR_TAB[k].chk;
                s.val             = DIR_TAB[k].val;
                batch.push_back(s);
            end
        end
        for (int k = 1; k <= 3; k++) begin
            s.req.req_type    = REQ_PIXEL;
            s.req.pixel_value = 16'(k);
            s.chk             = 1'b0;
            s.val             = '0;
            batch.push_back(s);
        end
        send_batch();

        while (items_used < RAND_ITEMS) begin
            wait_idle();
            random_settings();
            repeat ($urandom_range(1, 2)) random_plane();
            send_batch();
        end

        wait_idle();
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
